// ----- rtl/core/mpns_pkg.sv -----
package mpns_pkg;

  // Fixed field widths.
  localparam int NODE_W   = 6;
  localparam int CLASS_W  = 2;
  localparam int MASK_W   = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 64;

  // The node search runs over eight groups of eight nodes.
  localparam int GRP_N    = 8;
  localparam int GRP_W    = 8;
  localparam int GRP_IDX_W = 3;
  // Search masks in priority order: pass one from the start, pass one wrapped,
  // pass two from the start, pass two wrapped.
  localparam int SRCH_N   = 4;

  localparam int MAX_NODES_DEF = 64;

  localparam logic [CLASS_W-1:0] CLASS_FREE = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_LOW  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_OOM  = 2'd2;

  localparam logic OP_SELECT = 1'b0;
  localparam logic OP_NOTIFY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_NODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONLINE_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 2'd2;

  localparam logic POLICY_FIRST_FIT   = 1'b0;
  localparam logic POLICY_ROUND_ROBIN = 1'b1;

  typedef logic [NODE_W-1:0] node_tbl_t [MASK_W];

  typedef struct packed {
    logic notify;
    logic mask;
    logic group;
    logic pick;
    logic emit;
  } ctrl_cmd_t;

endpackage

// ----- rtl/core/memory_pressure_node_selector_top.sv -----
// Memory-pressure node selector: keeps a class per node and picks a target node.
// A notify is registered as a result on acceptance, while a select passes through the
// mask, group and pick states; either result then moves to the output register in the
// emit state, which waits while a full output register is not taken. The five-state
// sequencer serves one word at a time and takes no new word until the last is emitted.
// Reset (rst_ni low, asynchronous): every node free, no last pick, policy round-robin.
module memory_pressure_node_selector_top #(
  parameter int MAX_NODES = mpns_pkg::MAX_NODES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [mpns_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mpns_pkg::CFG_W-1:0]     cfg_wdata_i,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // source_node[5:0], mem_class[7:6]
  input  logic                           s_axis_tuser,  // opcode
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata   // found[0], chosen_node[6:1],
                                                        // lowmem_enable[7],
                                                        // lowmem_disable[8], zero[15:9]
);

  mpns_pkg::ctrl_cmd_t          cmd;
  logic                         found, lowmem_en, lowmem_dis;
  logic [mpns_pkg::NODE_W-1:0]  chosen_node;

  // The controller sequences each word: a notify is applied on acceptance, while a
  // select runs through mask build, grouped priority search and final choice.
  mpns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration, the class vectors, the last pick and the
  // output register that lets a finished word wait while the next one is taken.
  mpns_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_source_node_i     (s_axis_tdata[5:0]),
    .in_mem_class_i       (s_axis_tdata[7:6]),
    .out_found_o          (found),
    .out_chosen_node_o    (chosen_node),
    .out_lowmem_enable_o  (lowmem_en),
    .out_lowmem_disable_o (lowmem_dis)
  );

  assign m_axis_tdata = {7'd0, lowmem_dis, lowmem_en, chosen_node, found};

`ifndef NO_ASSERTIONS
  // In the cycle after a word is taken the sequencer is busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while the previous word is still in work");

  // A word without a found node carries node zero.
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:1] == 6'd0)
    else $error("chosen node set without a found node");

  // The low-memory flags exclude each other and never ride on a select result.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[7] && m_axis_tdata[8]) &&
                      !(m_axis_tdata[0] && (m_axis_tdata[7] || m_axis_tdata[8])))
    else $error("inconsistent result flags");
`endif

endmodule

// ----- rtl/core/mpns_ctrl.sv -----
module mpns_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_opcode_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mpns_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MASK  = 5'b00010,
    S_GROUP = 5'b00100,
    S_PICK  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_opcode_i == mpns_pkg::OP_NOTIFY) begin
            cmd_o.notify = 1'b1;
            state_d      = S_EMIT;
          end else begin
            state_d = S_MASK;
          end
        end
      end
      S_MASK: begin
        cmd_o.mask = 1'b1;
        state_d    = S_GROUP;
      end
      S_GROUP: begin
        cmd_o.group = 1'b1;
        state_d     = S_PICK;
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/mpns_dp.sv -----
module mpns_dp #(
  parameter int MAX_NODES = mpns_pkg::MAX_NODES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mpns_pkg::ctrl_cmd_t                cmd_i,
  input  logic                               cfg_we_i,
  input  logic [mpns_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mpns_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic [mpns_pkg::NODE_W-1:0]        in_source_node_i,
  input  logic [mpns_pkg::CLASS_W-1:0]       in_mem_class_i,
  output logic                               out_found_o,
  output logic [mpns_pkg::NODE_W-1:0]        out_chosen_node_o,
  output logic                               out_lowmem_enable_o,
  output logic                               out_lowmem_disable_o
);

  localparam int NW = mpns_pkg::NODE_W;
  localparam int MW = mpns_pkg::MASK_W;
  localparam int RING = (MAX_NODES < MW) ? MAX_NODES : MW;
  localparam logic [NW-1:0] RING_LAST = NW'(RING - 1);
  localparam logic [MW-1:0] RING_MASK = (MW'(1) << RING) - MW'(1);

  // Residue of every node number modulo the ring size, built by counting.
  function automatic mpns_pkg::node_tbl_t mod_table(input int ring);
    mpns_pkg::node_tbl_t tbl;
    int j;
    j = 0;
    for (int i = 0; i < MW; i++) begin
      tbl[i] = NW'(j);
      j = (j + 1 == ring) ? 0 : j + 1;
    end
    return tbl;
  endfunction

  localparam mpns_pkg::node_tbl_t MOD_TBL = mod_table(RING);

  function automatic logic [mpns_pkg::GRP_IDX_W-1:0] lowest8(
    input logic [mpns_pkg::GRP_W-1:0] v
  );
    logic [mpns_pkg::GRP_IDX_W-1:0] idx;
    idx = '0;
    for (int i = mpns_pkg::GRP_W - 1; i >= 0; i--) begin
      if (v[i]) idx = mpns_pkg::GRP_IDX_W'(i);
    end
    return idx;
  endfunction

  // Configuration registers.
  logic [NW-1:0] local_node_q;
  logic [MW-1:0] online_mask_q;
  logic          policy_mode_q;

  // Class table as one bit vector per class; reserved class three sets none.
  logic [MW-1:0] free_q, low_q, oom_q;
  logic [NW-1:0] last_pick_q;
  logic          last_valid_q;

  logic [MW-1:0] mask_q [mpns_pkg::SRCH_N];
  logic [mpns_pkg::GRP_N-1:0]     grp_any_q [mpns_pkg::SRCH_N];
  logic [mpns_pkg::GRP_IDX_W-1:0] grp_idx_q [mpns_pkg::SRCH_N][mpns_pkg::GRP_N];

  logic          res_found_q, res_en_q, res_dis_q;
  logic [NW-1:0] res_node_q;
  logic          out_found_q, out_en_q, out_dis_q;
  logic [NW-1:0] out_node_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_node_q  <= '0;
      online_mask_q <= '0;
      policy_mode_q <= mpns_pkg::POLICY_ROUND_ROBIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mpns_pkg::CFG_LOCAL_NODE:  local_node_q  <= cfg_wdata_i[NW-1:0];
        mpns_pkg::CFG_ONLINE_MASK: online_mask_q <= cfg_wdata_i;
        mpns_pkg::CFG_POLICY_MODE: policy_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Scan start.
  logic [NW-1:0] base, first;
  logic [MW-1:0] cand, ge_mask, p1, p2;

  always_comb begin
    base = last_valid_q ? last_pick_q : MOD_TBL[local_node_q];
    if (policy_mode_q == mpns_pkg::POLICY_FIRST_FIT && last_valid_q) begin
      first = last_pick_q;
    end else begin
      first = (base == RING_LAST) ? '0 : base + NW'(1);
    end
    cand    = online_mask_q & RING_MASK & ~(MW'(1) << local_node_q);
    ge_mask = {MW{1'b1}} << first;
    p1      = cand & free_q;
    p2      = cand & (free_q | low_q);
  end

  // Notify decode.
  logic note_ok, note_en, note_dis;

  always_comb begin
    note_ok  = (32'(in_source_node_i) < RING);
    note_en  = note_ok && (in_mem_class_i == mpns_pkg::CLASS_OOM);
    note_dis = note_ok && oom_q[in_source_node_i] &&
               ((in_mem_class_i == mpns_pkg::CLASS_FREE) ||
                (in_mem_class_i == mpns_pkg::CLASS_LOW));
  end

  // Final choice over the grouped search results.
  logic                           pick_any;
  logic [mpns_pkg::GRP_IDX_W-1:0] pick_grp, pick_bit;

  always_comb begin
    logic [mpns_pkg::GRP_IDX_W-1:0] g_sel;
    g_sel    = '0;
    pick_any = 1'b0;
    pick_grp = '0;
    pick_bit = '0;
    for (int m = mpns_pkg::SRCH_N - 1; m >= 0; m--) begin
      if (|grp_any_q[m]) begin
        g_sel = lowest8(grp_any_q[m]);
        pick_any = 1'b1;
        pick_grp = g_sel;
        pick_bit = grp_idx_q[m][g_sel];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q       <= '1;
      low_q        <= '0;
      oom_q        <= '0;
      last_pick_q  <= '0;
      last_valid_q <= 1'b0;
    end else begin
      if (cmd_i.notify && note_ok) begin
        free_q[in_source_node_i] <= (in_mem_class_i == mpns_pkg::CLASS_FREE);
        low_q[in_source_node_i]  <= (in_mem_class_i == mpns_pkg::CLASS_LOW);
        oom_q[in_source_node_i]  <= (in_mem_class_i == mpns_pkg::CLASS_OOM);
      end
      if (cmd_i.pick && pick_any) begin
        last_pick_q  <= {pick_grp, pick_bit};
        last_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mask) begin
      mask_q[0] <= p1 & ge_mask;
      mask_q[1] <= p1;
      mask_q[2] <= p2 & ge_mask;
      mask_q[3] <= p2;
    end
    if (cmd_i.group) begin
      for (int m = 0; m < mpns_pkg::SRCH_N; m++) begin
        for (int g = 0; g < mpns_pkg::GRP_N; g++) begin
          grp_any_q[m][g] <= |mask_q[m][g*mpns_pkg::GRP_W +: mpns_pkg::GRP_W];
          grp_idx_q[m][g] <= lowest8(mask_q[m][g*mpns_pkg::GRP_W +: mpns_pkg::GRP_W]);
        end
      end
    end
    if (cmd_i.notify) begin
      res_found_q <= 1'b0;
      res_node_q  <= '0;
      res_en_q    <= note_en;
      res_dis_q   <= note_dis;
    end else if (cmd_i.pick) begin
      res_found_q <= pick_any;
      res_node_q  <= pick_any ? {pick_grp, pick_bit} : '0;
      res_en_q    <= 1'b0;
      res_dis_q   <= 1'b0;
    end
    if (cmd_i.emit) begin
      out_found_q <= res_found_q;
      out_node_q  <= res_node_q;
      out_en_q    <= res_en_q;
      out_dis_q   <= res_dis_q;
    end
  end

  assign out_found_o          = out_found_q;
  assign out_chosen_node_o    = out_node_q;
  assign out_lowmem_enable_o  = out_en_q;
  assign out_lowmem_disable_o = out_dis_q;

endmodule

// ----- test/node_selector_checker.sv -----
module node_selector_checker
  import mpns_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // source_node[5:0], mem_class[7:6]
  input  logic                 s_axis_tuser,  // opcode
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [15:0]          m_axis_tdata,  // found[0], chosen_node[6:1],
                                              // lowmem_enable[7], lowmem_disable[8]
  output int                   pending_o,
  output int                   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = (MAX_NODES < 64) ? MAX_NODES : 64;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] node;
    logic              lowmem_en;
    logic              lowmem_dis;
  } pick_word_t;

  // Shadow of the block's state and registers.
  logic [CLASS_W-1:0] class_tbl [MASK_W];
  logic [NODE_W-1:0]  last_node;
  logic               last_ok;
  logic [NODE_W-1:0]  local_id;
  logic [MASK_W-1:0]  online;
  logic               policy;

  pick_word_t expected_words [$];
  int fails = 0;

  assign fail_count_o = fails;

  // Applies one input word to the shadow state and returns the word it should produce.
  function automatic pick_word_t next_pick_word(logic op, logic [NODE_W-1:0] src,
                                                logic [CLASS_W-1:0] cls);
    pick_word_t r;
    logic [CLASS_W-1:0] old;
    int first;
    int base;
    int node;
    r = '0;
    if (op == OP_NOTIFY) begin
      if (src < RING) begin
        old = class_tbl[src];
        class_tbl[src] = cls;
        r.lowmem_en  = (cls == CLASS_OOM);
        r.lowmem_dis = (cls == CLASS_FREE || cls == CLASS_LOW) && (old == CLASS_OOM);
      end
      return r;
    end
    if (policy == POLICY_FIRST_FIT) begin
      first = last_ok ? (int'(last_node) % RING) : ((int'(local_id) + 1) % RING);
    end else begin
      base  = last_ok ? int'(last_node) : int'(local_id);
      first = (base % RING + 1) % RING;
    end
    // The first pass wants a free node, the second settles for a low one.
    for (int pass = 0; pass < 2; pass++) begin
      for (int i = 0; i < RING; i++) begin
        node = (first + i) % RING;
        if (node != int'(local_id) && online[node] &&
            (class_tbl[node] == CLASS_FREE || (pass == 1 && class_tbl[node] == CLASS_LOW))) begin
          last_node = NODE_W'(node);
          last_ok   = 1'b1;
          r.found   = 1'b1;
          r.node    = NODE_W'(node);
          return r;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pick_word_t want;
    if (!rst_ni) begin
      for (int n = 0; n < MASK_W; n++) class_tbl[n] = CLASS_FREE;
      last_node = '0;
      last_ok   = 1'b0;
      local_id  = '0;
      online    = '0;
      policy    = POLICY_ROUND_ROBIN;
      expected_words.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOCAL_NODE:  local_id = cfg_wdata_i[NODE_W-1:0];
          CFG_ONLINE_MASK: online   = cfg_wdata_i[MASK_W-1:0];
          CFG_POLICY_MODE: policy   = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $error("output word %h arrived with nothing expected", m_axis_tdata);
          fails++;
        end else begin
          want = expected_words.pop_front();
          check_field("found", want.found, m_axis_tdata[0]);
          check_field("chosen_node", want.node, m_axis_tdata[6:1]);
          check_field("lowmem_enable", want.lowmem_en, m_axis_tdata[7]);
          check_field("lowmem_disable", want.lowmem_dis, m_axis_tdata[8]);
          check_field("padding", 0, m_axis_tdata[15:9]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words.push_back(next_pick_word(s_axis_tuser, s_axis_tdata[5:0],
                                                s_axis_tdata[7:6]));
      end
      pending_o <= expected_words.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
module testbench;
  import mpns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The fourth class value has no meaning in the block but must be stored all the same.
  localparam logic [CLASS_W-1:0] CLASS_RESERVED = 2'd3;
  // Length of the one long receiver hold-off, in clock cycles.
  localparam int HOLD_CYCLES = 300;
  localparam int N_PHASES = 12;
  localparam int WORDS_PER_PHASE = 125;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 s_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_tdata;
  logic                 s_tuser;
  logic                 m_axis_tvalid;
  logic                 m_tready;
  logic [15:0]          m_axis_tdata;

  // Handshake between the stimulus process and the receiver process.
  logic hold_req;
  logic rx_calm;

  int pending;
  int fail_count;

  int n_select = 0;
  int n_notify = 0;
  int n_settings = 0;
  bit tx_calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  memory_pressure_node_selector_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  node_selector_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Online masks range from everything up to nothing, with sparse and dense ones between.
  function automatic logic [MASK_W-1:0] random_mask();
    logic [MASK_W-1:0] m;
    m = '0;
    case ($urandom_range(0, 5))
      0: m = '1;
      1: m = '0;
      2: m = {$urandom, $urandom};
      3: repeat ($urandom_range(1, 3)) m[$urandom_range(0, 63)] = 1'b1;
      4: m = {$urandom, $urandom} & {$urandom, $urandom};
      default: m = ~(64'd1 << $urandom_range(0, 63));
    endcase
    return m;
  endfunction

  // Offers one word after an optional gap and returns at the edge where it is taken.
  // The valid line is left high so that a following word can go out back to back.
  task automatic send(logic op, logic [NODE_W-1:0] src, logic [CLASS_W-1:0] cls);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {cls, src};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OP_SELECT) n_select++;
    else n_notify++;
  endtask

  // Waits until every word sent has come back. The first edge lets the checker count the
  // word taken at the current edge; the extra cycles cover the block's own latency.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  // Writes all three registers once the block has gone quiet. Bits above a register's
  // width carry random junk, which the block must ignore.
  task automatic configure(logic [NODE_W-1:0] local_id, logic [MASK_W-1:0] mask,
                           logic policy);
    logic [CFG_W-1:0] data;
    wait_idle();
    data = {$urandom, $urandom};
    data[NODE_W-1:0] = local_id;
    write_reg(CFG_LOCAL_NODE, data);
    write_reg(CFG_ONLINE_MASK, mask);
    data = {$urandom, $urandom};
    data[0] = policy;
    write_reg(CFG_POLICY_MODE, data);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // A mix that keeps a fair share of nodes free or low so that selections keep hitting.
  task automatic send_random();
    logic op;
    logic [CLASS_W-1:0] cls;
    int r;
    op = ($urandom_range(0, 9) < 4) ? OP_SELECT : OP_NOTIFY;
    r = $urandom_range(0, 19);
    if (r < 8) cls = CLASS_FREE;
    else if (r < 13) cls = CLASS_LOW;
    else if (r < 18) cls = CLASS_OOM;
    else cls = CLASS_RESERVED;
    send(op, NODE_W'($urandom_range(0, 63)), cls);
  endtask

  // The receiver takes words at random, with one long hold-off on request. The hold-off
  // is counted here so that the sender keeps offering words while it lasts.
  initial begin : receiver
    int gap_left;
    int hold_left;
    gap_left  = 0;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        m_tready <= 1'b0;
        gap_left--;
      end else begin
        m_tready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) gap_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    logic [NODE_W-1:0] local_id;
    logic [MASK_W-1:0] mask;
    logic              policy;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_SELECT;
    hold_req  <= 1'b0;
    rx_calm   <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Straight out of reset nothing is online, so a selection must come back empty.
    // The notifies then walk node 63 in and out of the out-of-memory class, repeat it,
    // and store the reserved class.
    send(OP_SELECT, 6'd0, CLASS_FREE);
    send(OP_NOTIFY, 6'd63, CLASS_OOM);
    send(OP_NOTIFY, 6'd63, CLASS_OOM);
    send(OP_NOTIFY, 6'd63, CLASS_LOW);
    send(OP_NOTIFY, 6'd63, CLASS_OOM);
    send(OP_NOTIFY, 6'd63, CLASS_FREE);
    send(OP_NOTIFY, 6'd10, CLASS_RESERVED);
    send(OP_NOTIFY, 6'd0, CLASS_LOW);

    // First-fit with every node online: the first pick follows the local node and is
    // then repeated, until its class changes.
    configure(6'd5, '1, POLICY_FIRST_FIT);
    send(OP_SELECT, 6'd0, CLASS_FREE);
    send(OP_SELECT, 6'd0, CLASS_FREE);
    send(OP_NOTIFY, 6'd6, CLASS_OOM);
    send(OP_SELECT, 6'd0, CLASS_FREE);
    send(OP_NOTIFY, 6'd7, CLASS_LOW);
    send(OP_SELECT, 6'd0, CLASS_FREE);

    // Round-robin with only nodes 0, 10 and 63 online, 63 being local. The last pick has
    // gone offline, node 10 holds the reserved class and node 0 is low, so only the
    // second pass finds anything. Once node 0 is out of memory nothing is found at all.
    configure(6'd63, 64'h8000_0000_0000_0401, POLICY_ROUND_ROBIN);
    send(OP_SELECT, 6'd0, CLASS_FREE);
    send(OP_NOTIFY, 6'd0, CLASS_OOM);
    send(OP_SELECT, 6'd0, CLASS_FREE);
    send(OP_NOTIFY, 6'd0, CLASS_FREE);
    send(OP_SELECT, 6'd0, CLASS_FREE);
    send(OP_SELECT, 6'd0, CLASS_FREE);

    // Random phases, each under a fresh setting. The first two pin the local node to its
    // extremes; one phase runs with no idling at all, and another holds the receiver off
    // for a long stretch while words keep being offered, so that the block backs up.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0: begin
          local_id = 6'd0;
          mask     = '1;
          policy   = POLICY_FIRST_FIT;
        end
        1: begin
          local_id = 6'd63;
          mask     = '1;
          policy   = POLICY_ROUND_ROBIN;
        end
        default: begin
          local_id = NODE_W'($urandom_range(0, 63));
          mask     = random_mask();
          policy   = logic'($urandom_range(0, 1));
        end
      endcase
      configure(local_id, mask, policy);
      tx_calm = (phase == 3 || phase == 7);
      rx_calm <= (phase == 3);
      if (phase == 7) begin
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      repeat (WORDS_PER_PHASE) send_random();
    end
    tx_calm = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d words: %0d selections and %0d notifies, under %0d register settings.",
             n_select + n_notify, n_select, n_notify, n_settings);
    $display("Random idling on both sides, one quiet phase and one %0d-cycle receiver stall.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Far beyond the slowest correct run, even with every gap and stall at its longest.
  initial begin : watchdog
    #8_000_000;
    $display("Timed out with %0d words still outstanding.", pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
